// File: rtl/mclc_pkg.sv
// Shared types and codes for the MESI cache line controller.
`timescale 1ns / 1ps

package mclc_pkg;

    localparam int TAG_W   = 22;
    localparam int STAMP_W = 32;
    localparam int CORE_W  = 4;

    // Request types.
    localparam logic [1:0] REQ_PR_RD  = 2'd0;
    localparam logic [1:0] REQ_PR_WR  = 2'd1;
    localparam logic [1:0] REQ_SN_RD  = 2'd2;
    localparam logic [1:0] REQ_SN_RDX = 2'd3;

    // MESI line states.
    localparam logic [1:0] ST_I = 2'd0;
    localparam logic [1:0] ST_S = 2'd1;
    localparam logic [1:0] ST_E = 2'd2;
    localparam logic [1:0] ST_M = 2'd3;

    // Bus requests.
    localparam logic [1:0] BUS_NONE = 2'd0;
    localparam logic [1:0] BUS_RD   = 2'd1;
    localparam logic [1:0] BUS_RDX  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] address;
        logic        shared_line;
        logic [31:0] time_stamp;
    } req_item_t;

    typedef struct packed {
        logic              hit;
        logic [1:0]        prior_state;
        logic [1:0]        bus_request;
        logic              flush;
        logic [CORE_W-1:0] requester;
    } rsp_item_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [1:0]         state;
        logic [STAMP_W-1:0] stamp;
    } way_entry_t;

endpackage

// File: rtl/mclc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module mclc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/mesi_cache_line_controller_unit.sv
// Top level of the MESI tag and state controller for one set-associative cache.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   req     | in        | req_valid/req_stall | req_item (type, address, ...)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_item (hit, prior state, ...)
//   cfg     | in        | cfg_valid/cfg_ready | cfg_data (core number)
//
// An item is accepted every cycle while req_stall is low and passes through the
// lookup stage to the result register; its set row is read from the tag RAM at
// acceptance and written back as it leaves the lookup stage. A row written on the
// same edge as the next item's read is forwarded to it. Reset clears one valid bit
// per set, so no clearing pass is needed. While the result register is stalled and
// full, a full lookup stage holds and req_stall is raised; cfg_ready is always high.
`timescale 1ns / 1ps

module mesi_cache_line_controller_unit #(
    parameter int SETS        = 64,
    parameter int WAYS        = 2,
    parameter int BLOCK_BYTES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  mclc_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mclc_pkg::rsp_item_t rsp_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_data
);

    import mclc_pkg::*;

    // SETS and BLOCK_BYTES / 2 are taken as powers of two.
    localparam int OFFSET_BITS = $clog2(BLOCK_BYTES / 2);
    localparam int SET_BITS    = $clog2(SETS);
    localparam int SET_W       = (SETS > 1) ? SET_BITS : 1;
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W       = WAYS * $bits(way_entry_t);

    typedef way_entry_t [WAYS-1:0] row_t;

    logic              req_accept;
    logic              s1_adv;
    logic [31:0]       req_blk;
    logic [SET_W-1:0]  req_set;
    logic [31:0]       s1_blk;
    logic [SET_W-1:0]  s1_set;
    logic [TAG_W-1:0]  s1_tag;

    logic              s1_valid_reg, s1_valid_next;
    req_item_t         s1_item_reg;
    logic              byp_valid_reg, byp_valid_next;
    row_t              byp_row_reg;
    logic [SETS-1:0]   row_valid_reg, row_valid_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_item_t         rsp_item_reg, rsp_item_next;
    logic [CORE_W-1:0] core_number_reg, core_number_next;

    logic [ROW_W-1:0]  ram_rd_data;
    row_t              s1_row;
    row_t              new_row;
    logic              hit_any;
    logic [WAY_W-1:0]  hit_idx;
    logic              inv_any;
    logic [WAY_W-1:0]  inv_idx;
    logic [WAY_W-1:0]  lru_idx;
    logic [WAY_W-1:0]  victim;
    logic [1:0]        prior;

    assign s1_adv     = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = s1_valid_reg && !s1_adv;
    assign req_accept = req_valid && !req_stall;
    assign cfg_ready  = 1'b1;

    assign req_blk = req_item.address >> OFFSET_BITS;
    assign req_set = SET_W'(req_blk & 32'(SETS - 1));
    assign s1_blk  = s1_item_reg.address >> OFFSET_BITS;
    assign s1_set  = SET_W'(s1_blk & 32'(SETS - 1));
    assign s1_tag  = TAG_W'(s1_blk >> SET_BITS);

    mclc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_set),
        .wr_data (ROW_W'(new_row)),
        .rd_en   (req_accept),
        .rd_addr (req_set),
        .rd_data (ram_rd_data)
    );

    // Lookup, victim choice and MESI update for the item in the lookup stage.
    always_comb
    begin
        if (byp_valid_reg)
        begin
            s1_row = byp_row_reg;
        end
        else if (row_valid_reg[s1_set])
        begin
            s1_row = row_t'(ram_rd_data);
        end
        else
        begin
            s1_row = '0;
        end

        hit_any = 1'b0;
        hit_idx = '0;
        inv_any = 1'b0;
        inv_idx = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_any && s1_row[w].state != ST_I && s1_row[w].tag == s1_tag)
            begin
                hit_any = 1'b1;
                hit_idx = WAY_W'(w);
            end
            if (!inv_any && s1_row[w].state == ST_I)
            begin
                inv_any = 1'b1;
                inv_idx = WAY_W'(w);
            end
        end

        // Least stamped way; the lowest index wins a tie.
        lru_idx = '0;
        for (int w = 1; w < WAYS; w++)
        begin
            if (s1_row[w].stamp < s1_row[lru_idx].stamp)
            begin
                lru_idx = WAY_W'(w);
            end
        end
        victim = inv_any ? inv_idx : lru_idx;
        prior  = hit_any ? s1_row[hit_idx].state : ST_I;

        new_row       = s1_row;
        rsp_item_next = '0;
        rsp_item_next.hit         = hit_any;
        rsp_item_next.prior_state = prior;

        unique case (s1_item_reg.req_type) inside
            REQ_PR_RD, REQ_PR_WR:
            begin
                if (!hit_any)
                begin
                    new_row[victim].tag   = s1_tag;
                    new_row[victim].stamp = s1_item_reg.time_stamp;
                    if (s1_item_reg.req_type == REQ_PR_RD)
                    begin
                        rsp_item_next.bus_request = BUS_RD;
                        new_row[victim].state = s1_item_reg.shared_line ? ST_S : ST_E;
                    end
                    else
                    begin
                        rsp_item_next.bus_request = BUS_RDX;
                        new_row[victim].state = ST_M;
                    end
                end
                else
                begin
                    new_row[hit_idx].stamp = s1_item_reg.time_stamp;
                    if (s1_item_reg.req_type == REQ_PR_WR)
                    begin
                        if (prior == ST_S)
                        begin
                            rsp_item_next.bus_request = BUS_RDX;
                        end
                        new_row[hit_idx].state = ST_M;
                    end
                end
                if (rsp_item_next.bus_request != BUS_NONE)
                begin
                    rsp_item_next.requester = core_number_reg;
                end
            end
            REQ_SN_RD, REQ_SN_RDX:
            begin
                if (hit_any)
                begin
                    rsp_item_next.flush = (prior == ST_E) || (prior == ST_M);
                    if (s1_item_reg.req_type == REQ_SN_RD)
                    begin
                        if (rsp_item_next.flush)
                        begin
                            new_row[hit_idx].state = ST_S;
                        end
                    end
                    else
                    begin
                        new_row[hit_idx].state = ST_I;
                    end
                end
            end
            default:
            begin
                rsp_item_next = '0;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_adv ? 1'b0 : s1_valid_reg;
        if (req_accept)
        begin
            s1_valid_next = 1'b1;
        end

        // The row being written now is newer than what the RAM returns.
        byp_valid_next = byp_valid_reg;
        if (req_accept)
        begin
            byp_valid_next = s1_adv && (s1_set == req_set);
        end

        row_valid_next = row_valid_reg;
        if (s1_adv)
        begin
            row_valid_next[s1_set] = 1'b1;
        end

        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (s1_adv)
        begin
            rsp_valid_next = 1'b1;
        end

        core_number_next = core_number_reg;
        if (cfg_valid && cfg_ready)
        begin
            core_number_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            byp_valid_reg   <= 1'b0;
            row_valid_reg   <= '0;
            rsp_valid_reg   <= 1'b0;
            core_number_reg <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            byp_valid_reg   <= byp_valid_next;
            row_valid_reg   <= row_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
            core_number_reg <= core_number_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_item_reg <= req_item;
            byp_row_reg <= new_row;
        end
        if (s1_adv)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule
